FILE: design/fpr_pkg.sv
package fpr_pkg;

  // Fixed field widths of the access and result channels.
  localparam int IDX_W    = 5;
  localparam int FRAME_W  = 2;
  localparam int PHYS_W   = 3;
  localparam int EVPAGE_W = 4;
  localparam int CNT_W    = 16;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and start the table reads
    logic commit;  // resolve the access, update state and the result register
  } fpr_cmd_t;

  // One result, as held in the output register.
  typedef struct packed {
    logic                hit;
    logic [FRAME_W-1:0]  frame;
    logic [PHYS_W-1:0]   physical_index;
    logic                evicted_valid;
    logic [EVPAGE_W-1:0] evicted_page;
    logic                write_back;
    logic [CNT_W-1:0]    hit_total;
    logic [CNT_W-1:0]    miss_total;
    logic [CNT_W-1:0]    writeback_total;
  } fpr_result_t;

endpackage

FILE: design/fpr_if.sv
// Access request channel.
interface fpr_in_if import fpr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [IDX_W-1:0] element_index;

  modport source (output valid, output op, output element_index, input ready);
  modport sink (input valid, input op, input element_index, output ready);
endinterface

// Result channel.
interface fpr_out_if import fpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [FRAME_W-1:0]  frame;
  logic [PHYS_W-1:0]   physical_index;
  logic                evicted_valid;
  logic [EVPAGE_W-1:0] evicted_page;
  logic                write_back;
  logic [CNT_W-1:0]    hit_total;
  logic [CNT_W-1:0]    miss_total;
  logic [CNT_W-1:0]    writeback_total;

  modport source (
    output valid, output hit, output frame, output physical_index,
    output evicted_valid, output evicted_page, output write_back,
    output hit_total, output miss_total, output writeback_total,
    input ready
  );
  modport sink (
    input valid, input hit, input frame, input physical_index,
    input evicted_valid, input evicted_page, input write_back,
    input hit_total, input miss_total, input writeback_total,
    output ready
  );
endinterface

FILE: design/fpr_ctrl.sv
module fpr_ctrl import fpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output fpr_cmd_t cmd
);

  localparam logic S_IDLE    = 1'b0;
  localparam logic S_RESOLVE = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // A request is taken only when nothing is being resolved.
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = in_valid && in_ready;
  // The access resolves once the output register is free or being emptied.
  assign cmd.commit = (state_r == S_RESOLVE) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The output register fills on commit and empties when the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/fpr_datapath.sv
module fpr_datapath import fpr_pkg::*; #(
  parameter int VIRTUAL_PAGES = 16,
  parameter int FRAMES        = 4,
  parameter int PAGE_ELEMENTS = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fpr_cmd_t         cmd,
  input  logic             op,
  input  logic [IDX_W-1:0] element_index,
  output fpr_result_t      result
);

  localparam int PAGE_W = $clog2(VIRTUAL_PAGES);
  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OFF_W  = (PAGE_ELEMENTS > 1) ? $clog2(PAGE_ELEMENTS) : 1;
  localparam int IDX_N  = 1 << IDX_W;
  localparam int SUM_W  = (FIDX_W + OFF_W + 1 > PHYS_W) ? FIDX_W + OFF_W + 1 : PHYS_W;
  localparam logic [FIDX_W-1:0] LAST_FRAME = FIDX_W'(FRAMES - 1);

  // Index split tables, worked out at elaboration.
  logic [PAGE_W-1:0] page_lut [IDX_N];
  logic [OFF_W-1:0]  off_lut  [IDX_N];

  for (genvar i = 0; i < IDX_N; i++) begin : g_split
    assign page_lut[i] = PAGE_W'((i / PAGE_ELEMENTS) % VIRTUAL_PAGES);
    assign off_lut[i]  = OFF_W'(i % PAGE_ELEMENTS);
  end

  logic [PAGE_W-1:0] page_in;
  assign page_in = page_lut[element_index];

  // Page table: resident flags in flops, frame numbers in a memory.
  logic [VIRTUAL_PAGES-1:0] resident_r;
  logic [FIDX_W-1:0]        map_mem [VIRTUAL_PAGES];
  logic [PAGE_W-1:0]        owner_mem [FRAMES];

  // Frame state and replacement pointer.
  logic [FRAMES-1:0] used_r;
  logic [FRAMES-1:0] dirty_r;
  logic [FIDX_W-1:0] fifo_ptr_r;

  // Captured request and table read data.
  logic              op_r;
  logic [PAGE_W-1:0] page_r;
  logic [OFF_W-1:0]  off_r;
  logic              res_rd_r;
  logic [FIDX_W-1:0] map_rd_r;
  logic [PAGE_W-1:0] owner_rd_r;

  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0] wb_cnt_r, wb_cnt_nxt;

  logic              free_found;
  logic [FIDX_W-1:0] free_idx;
  logic [FIDX_W-1:0] fr_sel;
  logic              evict;
  logic              wb;
  logic [SUM_W-1:0]  phys_full;

  // Capture the request and read both tables on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= op;
      page_r     <= page_in;
      off_r      <= off_lut[element_index];
      res_rd_r   <= resident_r[page_in];
      map_rd_r   <= map_mem[page_in];
      owner_rd_r <= owner_mem[fifo_ptr_r];
    end
  end

  // Lowest-numbered free frame.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (!used_r[f]) begin
        free_found = 1'b1;
        free_idx   = FIDX_W'(f);
      end
    end
  end

  // Frame choice, eviction and write-back decision.
  assign evict     = !res_rd_r && !free_found;
  assign wb        = evict && dirty_r[fifo_ptr_r];
  assign fr_sel    = res_rd_r ? map_rd_r : (free_found ? free_idx : fifo_ptr_r);
  assign phys_full = SUM_W'(fr_sel) * SUM_W'(PAGE_ELEMENTS) + SUM_W'(off_r);

  // Saturating statistics counters.
  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    wb_cnt_nxt   = wb_cnt_r;
    if (res_rd_r) begin
      if (hit_cnt_r != '1) hit_cnt_nxt = hit_cnt_r + 1'b1;
    end else begin
      if (miss_cnt_r != '1) miss_cnt_nxt = miss_cnt_r + 1'b1;
    end
    if (wb && (wb_cnt_r != '1)) wb_cnt_nxt = wb_cnt_r + 1'b1;
  end

  // Memory writes for a loaded page.
  always_ff @(posedge clk) begin
    if (cmd.commit && !res_rd_r) begin
      map_mem[page_r]   <= fr_sel;
      owner_mem[fr_sel] <= page_r;
    end
  end

  // Residency, frame flags, pointer and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resident_r <= '0;
      used_r     <= '0;
      dirty_r    <= '0;
      fifo_ptr_r <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      wb_cnt_r   <= '0;
    end else if (cmd.commit) begin
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      wb_cnt_r   <= wb_cnt_nxt;
      if (!res_rd_r) begin
        if (evict) begin
          resident_r[owner_rd_r] <= 1'b0;
          fifo_ptr_r <= (fifo_ptr_r == LAST_FRAME) ? '0 : fifo_ptr_r + 1'b1;
        end
        resident_r[page_r] <= 1'b1;
        used_r[fr_sel]     <= 1'b1;
        dirty_r[fr_sel]    <= (op_r == OP_WRITE);
      end else if (op_r == OP_WRITE) begin
        dirty_r[fr_sel] <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.hit             <= res_rd_r;
      result.frame           <= FRAME_W'(fr_sel);
      result.physical_index  <= phys_full[PHYS_W-1:0];
      result.evicted_valid   <= evict;
      result.evicted_page    <= evict ? EVPAGE_W'(owner_rd_r) : '0;
      result.write_back      <= wb;
      result.hit_total       <= hit_cnt_nxt;
      result.miss_total      <= miss_cnt_nxt;
      result.writeback_total <= wb_cnt_nxt;
    end
  end

endmodule

FILE: design/fifo_page_replacement.sv
// FIFO page replacement residency manager.
// in_req carries one access request (op: read or write, element_index); it is
// split into a virtual page and an offset and looked up in the page table.
// out_rsp returns one result per request: hit flag, frame, physical index,
// any evicted page with its write-back flag, and three saturating counters.
// On acceptance the page table and the frame owner memory are read into
// registers; the access then resolves (free frame pick, FIFO eviction, table
// updates) into the output register once that register is free or being
// emptied. A new request is not taken until the earlier one has resolved.
// The output register lets a request be accepted while an earlier result is
// still waiting; if the sink stalls, the request under resolution waits and
// in_req.ready stays low until the output register is taken.
// Reset makes every page non-resident, all frames free and clean, and clears
// the FIFO pointer and counters at once; no clearing pass is needed.
module fifo_page_replacement import fpr_pkg::*; #(
  parameter int VIRTUAL_PAGES = 16,
  parameter int FRAMES        = 4,
  parameter int PAGE_ELEMENTS = 2
) (
  input logic         clk,
  input logic         rst_n,
  fpr_in_if.sink      in_req,
  fpr_out_if.source   out_rsp
);

  fpr_cmd_t    cmd;
  fpr_result_t result;
  logic        out_valid;

  // Sequencing and handshake.
  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  // Page table, frame state and counters.
  fpr_datapath #(
    .VIRTUAL_PAGES (VIRTUAL_PAGES),
    .FRAMES        (FRAMES),
    .PAGE_ELEMENTS (PAGE_ELEMENTS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .op            (in_req.op),
    .element_index (in_req.element_index),
    .result        (result)
  );

  // Result channel.
  assign out_rsp.valid           = out_valid;
  assign out_rsp.hit             = result.hit;
  assign out_rsp.frame           = result.frame;
  assign out_rsp.physical_index  = result.physical_index;
  assign out_rsp.evicted_valid   = result.evicted_valid;
  assign out_rsp.evicted_page    = result.evicted_page;
  assign out_rsp.write_back      = result.write_back;
  assign out_rsp.hit_total       = result.hit_total;
  assign out_rsp.miss_total      = result.miss_total;
  assign out_rsp.writeback_total = result.writeback_total;

  // A request is never taken in the same cycle as one resolves.
  a_load_commit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.commit))
    else $error("load and commit in the same cycle");

  // A resolved access is presented in the following cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_rsp.valid)
    else $error("committed result not presented");

  // A hit never evicts nor writes back.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.hit) |-> (!out_rsp.evicted_valid && !out_rsp.write_back))
    else $error("hit reported with an eviction");

  // A write-back only happens on an eviction.
  a_wb_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.write_back) |-> out_rsp.evicted_valid)
    else $error("write-back without eviction");

endmodule
